// ===== rtl/dsci_pkg.sv =====
// Shared constants, codes and types for the three-stack LIFO engine.
package dsci_pkg;

  // Stack geometry
  localparam int DEPTH   = 128;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS  = OP_W + DATA_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DATA_W + STAT_W + 3 * COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_A = 3'd0,
    OP_PUSH_B = 3'd1,
    OP_POP_A  = 3'd2,
    OP_POP_B  = 3'd3,
    OP_POP_R  = 3'd4,
    OP_CAT    = 3'd5,
    OP_ILV    = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_XFER,
    S_DONE
  } state_t;

  // Source of a pending transfer write
  typedef enum logic {
    SRC_A,
    SRC_B
  } src_t;

  // Control of one stack memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_ctl_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic               load;
    logic [DATA_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic [COUNT_W-1:0] count_r;
  } result_t;

endpackage

// ===== rtl/dsci_ram.sv =====
// Stack element memory: one write port, one registered read port.
module dsci_ram (
  input  logic                     clk,
  input  dsci_pkg::ram_ctl_t       ctl,
  output logic [dsci_pkg::DATA_W-1:0] q
);

  logic [dsci_pkg::DATA_W-1:0] mem [dsci_pkg::DEPTH];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    q <= mem[ctl.raddr];
  end

endmodule

// ===== rtl/dsci_seq.sv =====
// Command sequencer: fill counters and the shared pop/push transfer unit.
module dsci_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dsci_pkg::OP_W-1:0]   opcode,
  input  logic [dsci_pkg::DATA_W-1:0] value,
  input  logic                        out_free,
  input  logic [dsci_pkg::DATA_W-1:0] q_a,
  input  logic [dsci_pkg::DATA_W-1:0] q_b,
  input  logic [dsci_pkg::DATA_W-1:0] q_r,
  output dsci_pkg::ram_ctl_t          ctl_a,
  output dsci_pkg::ram_ctl_t          ctl_b,
  output dsci_pkg::ram_ctl_t          ctl_r,
  output dsci_pkg::result_t           res
);

  localparam logic [dsci_pkg::FILL_W-1:0] FULL = dsci_pkg::FILL_W'(dsci_pkg::DEPTH);
  localparam logic [dsci_pkg::FILL_W-1:0] ONE  = dsci_pkg::FILL_W'(1);

  dsci_pkg::state_t state, state_next;
  dsci_pkg::op_t    op, op_next;
  dsci_pkg::status_t status, status_next;
  dsci_pkg::src_t   pend_src, pend_src_next;
  dsci_pkg::src_t   turn, turn_next;
  logic             pend, pend_next;
  logic [dsci_pkg::DATA_W-1:0] rdata, rdata_next;
  logic [dsci_pkg::FILL_W-1:0] fill_a, fill_a_next;
  logic [dsci_pkg::FILL_W-1:0] fill_b, fill_b_next;
  logic [dsci_pkg::FILL_W-1:0] fill_r, fill_r_next;
  logic [dsci_pkg::FILL_W-1:0] fill_a_m1, fill_b_m1, fill_r_m1;
  logic             a_empty, b_empty, r_empty;
  logic             a_full, b_full, r_full;
  logic             accept;
  logic             xfer_end;
  dsci_pkg::op_t    in_op;

  assign in_op     = dsci_pkg::op_t'(opcode);
  assign fill_a_m1 = fill_a - ONE;
  assign fill_b_m1 = fill_b - ONE;
  assign fill_r_m1 = fill_r - ONE;
  assign a_empty   = (fill_a == '0);
  assign b_empty   = (fill_b == '0);
  assign r_empty   = (fill_r == '0);
  assign a_full    = (fill_a >= FULL);
  assign b_full    = (fill_b >= FULL);
  assign r_full    = (fill_r >= FULL);
  assign accept    = in_valid && in_ready;

  // Transfer is over once nothing is in flight and the sources are drained
  assign xfer_end = !pend && ((op == dsci_pkg::OP_CAT) ? b_empty : (a_empty && b_empty));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dsci_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            dsci_pkg::OP_POP_A: state_next = a_empty ? dsci_pkg::S_DONE : dsci_pkg::S_POP;
            dsci_pkg::OP_POP_B: state_next = b_empty ? dsci_pkg::S_DONE : dsci_pkg::S_POP;
            dsci_pkg::OP_POP_R: state_next = r_empty ? dsci_pkg::S_DONE : dsci_pkg::S_POP;
            dsci_pkg::OP_CAT:   state_next = dsci_pkg::S_XFER;
            dsci_pkg::OP_ILV:   state_next = dsci_pkg::S_XFER;
            default:            state_next = dsci_pkg::S_DONE;
          endcase
        end
      end
      dsci_pkg::S_POP:  state_next = dsci_pkg::S_DONE;
      dsci_pkg::S_XFER: begin
        if (xfer_end) begin
          state_next = dsci_pkg::S_DONE;
        end
      end
      dsci_pkg::S_DONE: begin
        if (out_free) begin
          state_next = dsci_pkg::S_IDLE;
        end
      end
      default: state_next = dsci_pkg::S_IDLE;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    in_ready    = (state == dsci_pkg::S_IDLE);
    res.load    = (state == dsci_pkg::S_DONE) && out_free;
    res.data    = rdata;
    res.status  = status;
    res.count_a = dsci_pkg::COUNT_W'(fill_a);
    res.count_b = dsci_pkg::COUNT_W'(fill_b);
    res.count_r = dsci_pkg::COUNT_W'(fill_r);
  end

  // Datapath: memory ports, fill counters and transfer bookkeeping
  always_comb begin
    op_next       = op;
    status_next   = status;
    pend_next     = pend;
    pend_src_next = pend_src;
    turn_next     = turn;
    rdata_next    = rdata;
    fill_a_next   = fill_a;
    fill_b_next   = fill_b;
    fill_r_next   = fill_r;

    ctl_a.we    = 1'b0;
    ctl_a.waddr = fill_a[dsci_pkg::ADDR_W-1:0];
    ctl_a.wdata = value;
    ctl_a.raddr = fill_a_m1[dsci_pkg::ADDR_W-1:0];
    ctl_b.we    = 1'b0;
    ctl_b.waddr = fill_b[dsci_pkg::ADDR_W-1:0];
    ctl_b.wdata = value;
    ctl_b.raddr = fill_b_m1[dsci_pkg::ADDR_W-1:0];
    ctl_r.we    = 1'b0;
    ctl_r.waddr = fill_r[dsci_pkg::ADDR_W-1:0];
    ctl_r.wdata = (pend_src == dsci_pkg::SRC_A) ? q_a : q_b;
    ctl_r.raddr = fill_r_m1[dsci_pkg::ADDR_W-1:0];

    case (state)
      // Decode a new request; pushes and pop issue happen here
      dsci_pkg::S_IDLE: begin
        if (accept) begin
          op_next     = in_op;
          status_next = dsci_pkg::ST_OK;
          rdata_next  = '0;
          pend_next   = 1'b0;
          turn_next   = dsci_pkg::SRC_A;
          case (in_op)
            dsci_pkg::OP_PUSH_A: begin
              if (a_full) begin
                status_next = dsci_pkg::ST_DROP;
              end else begin
                ctl_a.we    = 1'b1;
                fill_a_next = fill_a + ONE;
              end
            end
            dsci_pkg::OP_PUSH_B: begin
              if (b_full) begin
                status_next = dsci_pkg::ST_DROP;
              end else begin
                ctl_b.we    = 1'b1;
                fill_b_next = fill_b + ONE;
              end
            end
            dsci_pkg::OP_POP_A: begin
              if (a_empty) status_next = dsci_pkg::ST_EMPTY;
              else         fill_a_next = fill_a_m1;
            end
            dsci_pkg::OP_POP_B: begin
              if (b_empty) status_next = dsci_pkg::ST_EMPTY;
              else         fill_b_next = fill_b_m1;
            end
            dsci_pkg::OP_POP_R: begin
              if (r_empty) status_next = dsci_pkg::ST_EMPTY;
              else         fill_r_next = fill_r_m1;
            end
            dsci_pkg::OP_ILV: fill_r_next = '0;
            default: ;
          endcase
        end
      end

      // Capture the popped element from the registered read
      dsci_pkg::S_POP: begin
        case (op)
          dsci_pkg::OP_POP_A: rdata_next = q_a;
          dsci_pkg::OP_POP_B: rdata_next = q_b;
          default:            rdata_next = q_r;
        endcase
      end

      // One element a cycle: retire the previous pop, issue the next
      dsci_pkg::S_XFER: begin
        if (op == dsci_pkg::OP_CAT) begin
          ctl_a.wdata = q_b;
          if (pend) begin
            if (a_full) begin
              status_next = dsci_pkg::ST_DROP;
            end else begin
              ctl_a.we    = 1'b1;
              fill_a_next = fill_a + ONE;
            end
          end
          pend_next     = !b_empty;
          pend_src_next = dsci_pkg::SRC_B;
          if (!b_empty) begin
            fill_b_next = fill_b_m1;
          end
        end else begin
          if (pend) begin
            if (r_full) begin
              status_next = dsci_pkg::ST_DROP;
            end else begin
              ctl_r.we    = 1'b1;
              fill_r_next = fill_r + ONE;
            end
          end
          // Alternate sources, falling back to the other when one is drained
          if (!a_empty && ((turn == dsci_pkg::SRC_A) || b_empty)) begin
            fill_a_next   = fill_a_m1;
            pend_next     = 1'b1;
            pend_src_next = dsci_pkg::SRC_A;
            turn_next     = dsci_pkg::SRC_B;
          end else if (!b_empty) begin
            fill_b_next   = fill_b_m1;
            pend_next     = 1'b1;
            pend_src_next = dsci_pkg::SRC_B;
            turn_next     = dsci_pkg::SRC_A;
          end else begin
            pend_next     = 1'b0;
          end
        end
      end

      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dsci_pkg::S_IDLE;
      pend   <= 1'b0;
      fill_a <= '0;
      fill_b <= '0;
      fill_r <= '0;
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      fill_a <= fill_a_next;
      fill_b <= fill_b_next;
      fill_r <= fill_r_next;
    end
    op       <= op_next;
    status   <= status_next;
    pend_src <= pend_src_next;
    turn     <= turn_next;
    rdata    <= rdata_next;
  end

endmodule

// ===== rtl/dual_stack_concat_interleave.sv =====
// A request passes from IDLE through its sequencer states to the output register: push, no-op
// and pop of an empty stack go straight to DONE, pop captures its element in POP, and concatenate
// and interleave move one element a cycle through XFER via the shared pop/push unit and registered reads.
// A new request is taken only in IDLE, once the previous result has loaded into the output register;
// intake stalls while a finished result cannot load.
// Reset (rst, synchronous, active high) empties the stacks and clears the output valid.
module dual_stack_concat_interleave (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata: opcode[2:0], value[34:3], zero pad
  input  logic [dsci_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata: data[31:0], status[33:32], count_a[41:34], count_b[49:42], count_r[57:50], zero pad
  output logic [dsci_pkg::OUT_W-1:0] m_tdata
);

  dsci_pkg::ram_ctl_t ctl_a, ctl_b, ctl_r;
  dsci_pkg::result_t  res;
  logic [dsci_pkg::DATA_W-1:0] q_a, q_b, q_r;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  dsci_ram u_ram_a (.clk(clk), .ctl(ctl_a), .q(q_a));
  dsci_ram u_ram_b (.clk(clk), .ctl(ctl_b), .q(q_b));
  dsci_ram u_ram_r (.clk(clk), .ctl(ctl_r), .q(q_r));

  dsci_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .opcode   (s_tdata[dsci_pkg::OP_W-1:0]),
    .value    (s_tdata[dsci_pkg::OP_W +: dsci_pkg::DATA_W]),
    .out_free (out_free),
    .q_a      (q_a),
    .q_b      (q_b),
    .q_r      (q_r),
    .ctl_a    (ctl_a),
    .ctl_b    (ctl_b),
    .ctl_r    (ctl_r),
    .res      (res)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.load) begin
      m_tdata <= {{dsci_pkg::OUT_PAD{1'b0}}, res.count_r, res.count_b, res.count_a,
                  res.status, res.data};
    end
  end

endmodule
